/* rtl/core/hci_uart_packet_deframer_top_assert.svh */
// Assertion macros used by the checker of the deframer.
`ifndef HCI_UART_PACKET_DEFRAMER_TOP_ASSERT_SVH
`define HCI_UART_PACKET_DEFRAMER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HUD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HUD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

/* rtl/core/hud_pkg.sv */
package hud_pkg;

    localparam logic [7:0] TYPE_ACL   = 8'd2;
    localparam logic [7:0] TYPE_EVENT = 8'd4;

    localparam logic [2:0] ACL_HEADER_BYTES   = 3'd4;
    localparam logic [2:0] EVENT_HEADER_BYTES = 3'd2;

    localparam logic KIND_ACL   = 1'b0;
    localparam logic KIND_EVENT = 1'b1;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        packet_kind;
        logic        first_of_packet;
        logic        last_of_packet;
        logic        bad_type;
        logic [16:0] packet_length;
    } t_result;

endpackage

/* rtl/core/hud_parser.sv */
module hud_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    output hud_pkg::t_result o_result
);

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    logic [1:0]  r_phase;
    logic        r_kind;
    logic [2:0]  r_header_left;
    logic [7:0]  r_length_low;
    logic [15:0] r_payload_left;
    logic [16:0] r_byte_count;

    logic [1:0]  n_phase;
    logic        n_kind;
    logic [2:0]  n_header_left;
    logic [7:0]  n_length_low;
    logic [15:0] n_payload_left;
    logic [16:0] n_byte_count;

    logic [16:0] count_inc;
    logic [2:0]  header_dec;
    logic [15:0] payload_dec;
    logic [15:0] header_len;

    assign count_inc   = r_byte_count + 17'd1;
    assign header_dec  = r_header_left - 3'd1;
    assign payload_dec = r_payload_left - 16'd1;
    assign header_len  = (r_kind == hud_pkg::KIND_ACL) ? {i_byte, r_length_low}
                                                        : {8'd0, i_byte};

    always_comb begin
        n_phase        = r_phase;
        n_kind         = r_kind;
        n_header_left  = r_header_left;
        n_length_low   = r_length_low;
        n_payload_left = r_payload_left;
        n_byte_count   = r_byte_count;

        o_result                 = '0;
        o_result.data_byte       = i_byte;

        case (r_phase)
            PH_HEADER: begin
                n_byte_count         = count_inc;
                n_header_left        = header_dec;
                o_result.packet_kind = r_kind;
                if (r_kind == hud_pkg::KIND_ACL && header_dec == 3'd1) begin
                    n_length_low = i_byte;
                end
                if (header_dec == 3'd0) begin
                    if (header_len == 16'd0) begin
                        o_result.last_of_packet = 1'b1;
                        o_result.packet_length  = count_inc;
                        n_phase                 = PH_IDLE;
                        n_payload_left          = 16'd0;
                    end else begin
                        n_payload_left = header_len;
                        n_phase        = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_byte_count         = count_inc;
                n_payload_left       = payload_dec;
                o_result.packet_kind = r_kind;
                if (payload_dec == 16'd0) begin
                    o_result.last_of_packet = 1'b1;
                    o_result.packet_length  = count_inc;
                    n_phase                 = PH_IDLE;
                    n_header_left           = 3'd0;
                end
            end
            default: begin
                if (i_byte inside {hud_pkg::TYPE_ACL, hud_pkg::TYPE_EVENT}) begin
                    n_kind         = (i_byte == hud_pkg::TYPE_EVENT) ? hud_pkg::KIND_EVENT
                                                                     : hud_pkg::KIND_ACL;
                    n_header_left  = (i_byte == hud_pkg::TYPE_EVENT)
                                   ? hud_pkg::EVENT_HEADER_BYTES
                                   : hud_pkg::ACL_HEADER_BYTES;
                    n_byte_count   = 17'd1;
                    n_length_low   = 8'd0;
                    n_payload_left = 16'd0;
                    n_phase        = PH_HEADER;
                    o_result.packet_kind     = n_kind;
                    o_result.first_of_packet = 1'b1;
                end else begin
                    n_phase           = PH_IDLE;
                    o_result.bad_type = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_kind         <= hud_pkg::KIND_ACL;
            r_header_left  <= 3'd0;
            r_length_low   <= 8'd0;
            r_payload_left <= 16'd0;
            r_byte_count   <= 17'd0;
        end else if (i_fire) begin
            r_phase        <= n_phase;
            r_kind         <= n_kind;
            r_header_left  <= n_header_left;
            r_length_low   <= n_length_low;
            r_payload_left <= n_payload_left;
            r_byte_count   <= n_byte_count;
        end
    end

endmodule

/* rtl/core/hci_uart_packet_deframer_top.sv */
// HCI UART (H4) packet deframer. Each received byte comes out again, one
// result per byte, tagged with its packet kind (ACL or event), first and
// last marks, and on the last byte the total packet length including the
// type byte. A byte other than an ACL or event type byte where a packet
// should start is flagged as a bad type and the block keeps waiting for a
// type byte. A byte is taken every clock cycle while the output is not
// stalled; each byte passes through the input register and then the
// result register, with the packet state updated by the parser in
// between.
module hci_uart_packet_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_data_byte,
    output logic        o_packet_kind,
    output logic        o_first_of_packet,
    output logic        o_last_of_packet,
    output logic        o_bad_type,
    output logic [16:0] o_packet_length
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    hud_pkg::t_result r_out;

    logic             advance;
    logic             fire;
    hud_pkg::t_result step_result;

    assign advance = !r_out_valid || !i_stall;
    assign fire    = r_in_valid && advance;
    assign o_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    hud_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_byte   (r_in_byte),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= step_result;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_data_byte       = r_out.data_byte;
    assign o_packet_kind     = r_out.packet_kind;
    assign o_first_of_packet = r_out.first_of_packet;
    assign o_last_of_packet  = r_out.last_of_packet;
    assign o_bad_type        = r_out.bad_type;
    assign o_packet_length   = r_out.packet_length;

endmodule

/* rtl/core/hud_checker.sv */
`include "hci_uart_packet_deframer_top_assert.svh"

module hud_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_data_byte,
    input logic        o_packet_kind,
    input logic        o_first_of_packet,
    input logic        o_last_of_packet,
    input logic        o_bad_type,
    input logic [16:0] o_packet_length
);

    logic        bad_marks_clear;
    logic        event_length_ok;
    logic [28:0] out_fields;

    assign bad_marks_clear = !o_first_of_packet && !o_last_of_packet && !o_packet_kind
                             && (o_packet_length == 17'd0);
    assign event_length_ok = (o_packet_length >= 17'd3) && (o_packet_length <= 17'd258);
    assign out_fields      = {o_data_byte, o_packet_kind, o_first_of_packet,
                              o_last_of_packet, o_bad_type, o_packet_length};

    // A dropped type byte carries no packet marks and no length.
    `HUD_ASSERT_SAME(a_bad_type_clean, o_valid && o_bad_type, bad_marks_clear)

    // The length is shown only on the last byte of a packet.
    `HUD_ASSERT_SAME(a_length_on_last, o_valid && !o_last_of_packet, o_packet_length == 17'd0)

    // An event packet holds a type byte, two header bytes and at most 255 payload bytes.
    `HUD_ASSERT_SAME(a_event_length, o_valid && o_last_of_packet && o_packet_kind, event_length_ok)

    // A stalled result stays in place.
    `HUD_ASSERT_NEXT(a_stall_hold, o_valid && i_stall, o_valid && $stable(out_fields))

endmodule

bind hci_uart_packet_deframer_top hud_checker u_checker (.*);
